// ===== sv/som_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the neighborhood exp table for the SOM search/update block.
// No dependencies; every other file imports this package.
package som_pkg;

	localparam int MAX_NEURONS     = 8192;
	localparam int MAX_DIMS        = 16;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_SPAN        = 12;

	localparam int NRN_W   = $clog2(MAX_NEURONS);
	localparam int NCNT_W  = NRN_W + 1;
	localparam int DIM_W   = $clog2(MAX_DIMS);
	localparam int ADDR_W  = NRN_W + DIM_W;
	localparam int EXP_W   = $clog2(EXP_TABLE_DEPTH);
	localparam int CNT_W   = 5;
	localparam int H_W     = 25;
	localparam int CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
	localparam logic [H_W-1:0]   H_ONE     = 25'h1000000;
	localparam logic [H_W-1:0]   H_MIN     = 25'd168;

	// divider: quotient bits produced one per cycle
	localparam int NUM_W = 41;
	localparam int DEN_W = 37;
	localparam int QUO_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INIT_RATE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_RADIUS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_DECAY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_DECAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_DIMS  = 3'd6;

	typedef enum logic [1:0] {
		ACT_SEARCH = 2'd0,
		ACT_TRAIN  = 2'd1,
		ACT_WRITE  = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_LEN = 2'd1,
		ST_IDX = 2'd2
	} status_t;

	typedef struct packed {
		action_t            action;
		logic signed [15:0] element;
		logic               last;
		logic [12:0]        neuron_index;
		logic [3:0]         dim_index;
		logic signed [15:0] reward_scale;
	} req_t;

	typedef struct packed {
		logic [12:0]        winner;
		logic [36:0]        best_distance;
		logic signed [15:0] read_value;
		status_t            status;
	} rsp_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [NUM_W-1:0] rem;
	} div_rsp_t;

	typedef logic [H_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

	// exp(-k*span/depth) in Q1.24 by integer recurrence from a Taylor-series step
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t          rom;
		logic [63:0]       s;
		logic [63:0]       term;
		logic [63:0]       cur;
		logic signed [63:0] sum;
		int                Nterm;
		int                k;
		s    = (64'(EXP_SPAN) << 32) / 64'(EXP_TABLE_DEPTH);
		term = 64'h1_0000_0000;
		sum  = 64'sh1_0000_0000;
		cur  = 64'h1_0000_0000;
		for (Nterm = 1; Nterm <= 12; Nterm++) begin
			term = ((term * s) >> 32) / 64'(Nterm);
			if ((Nterm % 2) == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		rom[0] = H_ONE;
		for (k = 1; k < EXP_TABLE_DEPTH; k++) begin
			cur    = (cur * 64'(sum) + 64'h8000_0000) >> 32;
			rom[k] = H_W'((cur + 64'd128) >> 8);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== sv/som_wmem.sv =====
`timescale 1ns / 1ps
// Weight store: one write port, one read port, registered read data.
// Depends on som_pkg for depth and address width.
module som_wmem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [som_pkg::ADDR_W-1:0] waddr,
	input  logic [15:0]                wdata,
	input  logic [som_pkg::ADDR_W-1:0] raddr,
	output logic [15:0]                rdata
);
	import som_pkg::*;

	logic [15:0] mem [MAX_NEURONS*MAX_DIMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/som_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; caller keeps num below den << QUO_W.
// Depends on som_pkg for widths and the request/response structs.
module som_div (
	input  logic              clk,
	input  logic              arst_n,
	input  som_pkg::div_req_t req,
	output som_pkg::div_rsp_t rsp
);
	import som_pkg::*;

	logic [NUM_W-1:0]         rem_q;
	logic [DEN_W+QUO_W-2:0]   dsh_q;
	logic [QUO_W-1:0]         quo_q;
	logic [$clog2(QUO_W)-1:0] cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DEN_W+QUO_W-2:0]   rem_x;
	logic                     ge;

	assign rem_x = (DEN_W+QUO_W-1)'(rem_q);
	assign ge    = rem_x >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(QUO_W))'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= {req.den, (QUO_W-1)'(0)};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= NUM_W'(rem_x - dsh_q);
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== sv/som_bmu_search_and_update_unit.sv =====
`timescale 1ns / 1ps
// A non-final element is stored and counted; a weight write goes to EMIT, a read via RDW.
// Search reads every neuron's elements through the pipeline. Train: a winner divide, then per
// neuron d2, table-index divide and update; far neurons skip the divide and the update.
// Throughput: one item at a time; the output register lets the next item in while a word waits.
// Reset (arst_n low): control, element count, rate and radius cleared to config defaults;
// the weight memory is not cleared and reads undefined until written.
module som_bmu_search_and_update_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  som_pkg::req_t                 req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output som_pkg::rsp_t                 rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [som_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import som_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RDW   = 11'b00000000010,
		S_SRCH  = 11'b00000000100,
		S_WDIV  = 11'b00000001000,
		S_D2    = 11'b00000010000,
		S_H     = 11'b00000100000,
		S_KDIV  = 11'b00001000000,
		S_ALPHA = 11'b00010000000,
		S_UPD   = 11'b00100000000,
		S_NEXT  = 11'b01000000000,
		S_EMIT  = 11'b10000000000
	} state_t;

	// configuration and decaying parameters
	logic [15:0]      init_rate_q, init_radius_q, rate_decay_q, radius_decay_q;
	logic [7:0]       rows_q, cols_q;
	logic [4:0]       dims_q;
	logic [15:0]      rate_q, radius_q;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             iss_q;
	logic             rsp_valid_q;
	rsp_t             rsp_data_q;
	rsp_t             res_q;

	logic signed [15:0] vec_q [MAX_DIMS];
	logic [NRN_W-1:0]   i_q;
	logic [DIM_W-1:0]   j_q;
	logic [7:0]         row_q, col_q, wr_q, wc_q;
	logic [NRN_W-1:0]   win_q;
	logic [18:0]        eff_q;
	logic [31:0]        r2_q;
	logic [DEN_W-1:0]   den_q;
	logic [16:0]        d2_q;
	logic [H_W-1:0]     h_q;
	logic [19:0]        alpha_q;
	logic [36:0]        acc_q, best_q;
	logic [NRN_W-1:0]   best_win_q;

	// read pipeline: s1 = memory data back, s2 = product registered
	logic               v_s1, v_s2;
	logic [DIM_W-1:0]   j_s1, j_s2;
	logic               last_s1, last_s2, first_s1, first_s2;
	logic [NRN_W-1:0]   i_s1, i_s2;
	logic signed [37:0] prod_s2;
	logic signed [15:0] w_s2;

	// combinational
	logic [15:0]        n_raw;
	logic [NCNT_W-1:0]  n_cnt, n_m1;
	logic               dims_ok;
	logic [4:0]         dims_m1;
	logic [CNT_W:0]     total;
	logic               is_mem, mem_bad, len_bad, idx_bad;
	logic [14:0]        rew;
	logic [30:0]        eff_prod;
	logic [18:0]        eff_new;
	logic               idle_fire, wr_mem, train_go, decay_now, h_far, h_start;
	logic               i_last, j_last, pipe_idle, emit_ok, rd_issue;
	logic [31:0]        rate_dec, radius_dec;
	logic signed [8:0]  dr, dc;
	logic [7:0]         adr, adc;
	logic [43:0]        ah;
	logic signed [15:0] x_s1, w_s1;
	logic signed [16:0] diff_s1;
	logic signed [20:0] mul_a;
	logic signed [37:0] prod;
	logic signed [38:0] rq;
	logic signed [22:0] dlt;
	logic signed [23:0] nw;
	logic [15:0]        nw_sat;
	logic [36:0]        acc_nx;
	logic               we;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [15:0]        wdata, rdata;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign cfg_ready = 1'b1;
	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// neuron count saturates at capacity
	assign n_raw   = rows_q * cols_q;
	assign n_cnt   = (n_raw > 16'(MAX_NEURONS)) ? NCNT_W'(MAX_NEURONS) : n_raw[NCNT_W-1:0];
	assign n_m1    = n_cnt - 1'b1;
	assign dims_ok = (dims_q != '0) && (dims_q <= 5'(MAX_DIMS));
	assign dims_m1 = dims_q - 1'b1;
	assign total   = {1'b0, cnt_q} + 1'b1;

	assign is_mem  = (req_data.action == ACT_WRITE) || (req_data.action == ACT_READ);
	assign mem_bad = ({1'b0, req_data.neuron_index} >= n_cnt) || !dims_ok ||
	                 ({1'b0, req_data.dim_index} >= dims_q);
	assign len_bad = !dims_ok || (total != {1'b0, dims_q});
	assign idx_bad = (n_cnt == '0) ||
	                 ((req_data.action == ACT_TRAIN) && ({1'b0, req_data.neuron_index} >= n_cnt));

	// effective rate: negative reward acts as zero
	assign rew      = req_data.reward_scale[15] ? 15'd0 : req_data.reward_scale[14:0];
	assign eff_prod = rate_q * rew;
	assign eff_new  = eff_prod[30:12];

	assign idle_fire = (state_q == S_IDLE) && req_valid;
	assign wr_mem    = idle_fire && (req_data.action == ACT_WRITE) && !mem_bad;
	assign train_go  = idle_fire && !is_mem && req_data.last && !len_bad && !idx_bad &&
	                   (req_data.action == ACT_TRAIN);

	assign i_last    = {1'b0, i_q} == n_m1;
	assign j_last    = {1'b0, j_q} == dims_m1;
	assign pipe_idle = !iss_q && !v_s1 && !v_s2;
	assign emit_ok   = !rsp_valid_q || !rsp_stall;
	assign rd_issue  = iss_q && ((state_q == S_SRCH) || (state_q == S_UPD));

	// decay after a finished update, or at once when the effective rate is zero
	assign decay_now  = (train_go && (eff_new == '0)) || ((state_q == S_NEXT) && i_last);
	assign rate_dec   = rate_q * rate_decay_q;
	assign radius_dec = radius_q * radius_decay_q;

	// grid distance to the winner
	assign dr  = $signed({1'b0, row_q}) - $signed({1'b0, wr_q});
	assign dc  = $signed({1'b0, col_q}) - $signed({1'b0, wc_q});
	assign adr = dr[8] ? 8'(-dr) : dr[7:0];
	assign adc = dc[8] ? 8'(-dc) : dc[7:0];

	// table index k >= depth exactly when d2 << 16 >= den
	assign h_far   = DEN_W'({d2_q, 16'b0}) >= den_q;
	assign h_start = (state_q == S_H) && (den_q != '0) && !h_far;
	assign ah      = eff_q * h_q;

	assign div_req.start = (train_go && (eff_new != '0)) || h_start;
	assign div_req.num   = (state_q == S_IDLE) ? NUM_W'(req_data.neuron_index) : {d2_q, 24'b0};
	assign div_req.den   = (state_q == S_IDLE) ? DEN_W'(cols_q) : den_q;

	// stage 1: one shared signed multiplier, square for search, alpha*diff for update
	assign x_s1    = vec_q[j_s1];
	assign w_s1    = $signed(rdata);
	assign diff_s1 = $signed({x_s1[15], x_s1}) - $signed({w_s1[15], w_s1});
	assign mul_a   = (state_q == S_UPD) ? $signed({1'b0, alpha_q}) :
	                 $signed({{4{diff_s1[16]}}, diff_s1});
	assign prod    = mul_a * diff_s1;

	// stage 2 update: round half up, saturate
	assign rq     = $signed({prod_s2[37], prod_s2}) + 39'sd32768;
	assign dlt    = rq[38:16];
	assign nw     = $signed({{8{w_s2[15]}}, w_s2}) + $signed({dlt[22], dlt});
	assign nw_sat = (nw > 24'sd32767) ? 16'h7FFF : (nw < -24'sd32768) ? 16'h8000 : nw[15:0];
	assign acc_nx = acc_q + {3'b0, prod_s2[33:0]};

	assign we    = wr_mem || ((state_q == S_UPD) && v_s2);
	assign waddr = (state_q == S_UPD) ? {i_q, j_s2} :
	               {req_data.neuron_index, req_data.dim_index};
	assign wdata = (state_q == S_UPD) ? nw_sat : req_data.element;
	assign raddr = (state_q == S_IDLE) ? {req_data.neuron_index, req_data.dim_index} :
	               {i_q, j_q};

	som_wmem u_wmem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	som_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			iss_q          <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			rsp_valid_q    <= 1'b0;
			init_rate_q    <= 16'd9830;
			init_radius_q  <= 16'd12800;
			rate_decay_q   <= 16'd65523;
			radius_decay_q <= 16'd65529;
			rows_q         <= 8'd100;
			cols_q         <= 8'd50;
			dims_q         <= 5'd13;
			rate_q         <= 16'd9830;
			radius_q       <= 16'd12800;
		end else begin
			if (decay_now) begin
				rate_q   <= rate_dec[31:16];
				radius_q <= radius_dec[31:16];
			end
			// register writes; a write to a starting value reloads the live value
			if (cfg_valid) begin
				case (cfg_index)
					REG_INIT_RATE: begin
						init_rate_q <= cfg_data;
						rate_q      <= cfg_data;
					end
					REG_INIT_RADIUS: begin
						init_radius_q <= cfg_data;
						radius_q      <= cfg_data;
					end
					REG_RATE_DECAY:   rate_decay_q   <= cfg_data;
					REG_RADIUS_DECAY: radius_decay_q <= cfg_data;
					REG_GRID_ROWS:    rows_q         <= cfg_data[7:0];
					REG_GRID_COLS:    cols_q         <= cfg_data[7:0];
					REG_VECTOR_DIMS:  dims_q         <= cfg_data[4:0];
					default: ;
				endcase
			end

			v_s1 <= rd_issue;
			v_s2 <= v_s1;

			// output register: load on emit, drop once taken
			if ((state_q == S_EMIT) && emit_ok) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (is_mem) begin
							state_q <= ((req_data.action == ACT_READ) && !mem_bad) ? S_RDW : S_EMIT;
						end else if (!req_data.last) begin
							cnt_q <= (total > {1'b0, COUNT_MAX}) ? COUNT_MAX : total[CNT_W-1:0];
						end else begin
							cnt_q <= '0;
							if (len_bad || idx_bad) begin
								state_q <= S_EMIT;
							end else if (req_data.action == ACT_SEARCH) begin
								state_q <= S_SRCH;
								iss_q   <= 1'b1;
							end else if (eff_new == '0) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_WDIV;
							end
						end
					end
				end
				S_RDW: state_q <= S_EMIT;
				S_SRCH: begin
					if (iss_q && j_last && i_last) iss_q <= 1'b0;
					if (pipe_idle) state_q <= S_EMIT;
				end
				S_WDIV: begin
					if (div_rsp.done) state_q <= S_D2;
				end
				S_D2: state_q <= S_H;
				S_H: begin
					state_q <= h_start ? S_KDIV : S_ALPHA;
				end
				S_KDIV: begin
					if (div_rsp.done) state_q <= S_ALPHA;
				end
				S_ALPHA: begin
					if (h_q < H_MIN) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_UPD;
						iss_q   <= 1'b1;
					end
				end
				S_UPD: begin
					// drain before the next neuron: no read-after-write overlap
					if (iss_q && j_last) iss_q <= 1'b0;
					if (pipe_idle) state_q <= S_NEXT;
				end
				S_NEXT: begin
					state_q <= i_last ? S_EMIT : S_D2;
				end
				S_EMIT: begin
					if (emit_ok) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (idle_fire && !is_mem && (cnt_q < CNT_W'(MAX_DIMS))) begin
			vec_q[cnt_q[DIM_W-1:0]] <= req_data.element;
		end

		j_s1     <= j_q;
		last_s1  <= j_last;
		first_s1 <= i_q == '0;
		i_s1     <= i_q;
		j_s2     <= j_s1;
		last_s2  <= last_s1;
		first_s2 <= first_s1;
		i_s2     <= i_s1;
		prod_s2  <= prod;
		w_s2     <= w_s1;

		if ((state_q == S_EMIT) && emit_ok) rsp_data_q <= res_q;

		// close one neuron's distance; lowest index keeps ties
		if ((state_q == S_SRCH) && v_s2) begin
			if (last_s2) begin
				acc_q <= '0;
				if (first_s2 || (acc_nx < best_q)) begin
					best_q     <= acc_nx;
					best_win_q <= i_s2;
				end
			end else begin
				acc_q <= acc_nx;
			end
		end

		case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				i_q   <= '0;
				j_q   <= '0;
				win_q <= req_data.neuron_index;
				eff_q <= eff_new;
				r2_q  <= radius_q * radius_q;
				if (idle_fire) begin
					res_q <= '0;
					if (is_mem) res_q.status <= mem_bad ? ST_IDX : ST_OK;
					else if (len_bad) res_q.status <= ST_LEN;
					else if (idx_bad) res_q.status <= ST_IDX;
					else res_q.status <= ST_OK;
				end
			end
			S_RDW: res_q.read_value <= $signed(rdata);
			S_SRCH: begin
				if (iss_q) begin
					if (j_last) begin
						j_q <= '0;
						if (!i_last) i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				if (pipe_idle) begin
					res_q.winner        <= best_win_q;
					res_q.best_distance <= best_q;
				end
			end
			S_WDIV: begin
				if (div_rsp.done) begin
					wr_q  <= div_rsp.quo[7:0];
					wc_q  <= div_rsp.rem[7:0];
					den_q <= DEN_W'({r2_q, 4'b0}) + DEN_W'({r2_q, 3'b0});
					i_q   <= '0;
					row_q <= '0;
					col_q <= '0;
				end
			end
			S_D2: d2_q <= 17'(adr * adr) + 17'(adc * adc);
			S_H: begin
				if (den_q == '0) h_q <= (d2_q == '0) ? H_ONE : '0;
				else if (h_far) h_q <= '0;
			end
			S_KDIV: begin
				if (div_rsp.done) h_q <= EXP_ROM[div_rsp.quo[EXP_W-1:0]];
			end
			S_ALPHA: begin
				alpha_q <= ah[43:24];
				j_q     <= '0;
			end
			S_UPD: begin
				if (iss_q && !j_last) j_q <= j_q + 1'b1;
			end
			S_NEXT: begin
				if (!i_last) begin
					i_q <= i_q + 1'b1;
					if (col_q == cols_q - 1'b1) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/som_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the SOM search/update block, bound to the top level.
// Depends on som_pkg and som_bmu_search_and_update_unit.
module som_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input som_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input som_pkg::rsp_t rsp_data
);
	import som_pkg::*;

	// hold a stalled result word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status != 2'd3)
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |->
		rsp_data.winner == '0 && rsp_data.best_distance == '0 && rsp_data.read_value == '0)
		else $error("error result carries data");

	a_mem_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall &&
		(req_data.action == ACT_WRITE || req_data.action == ACT_READ) |=> req_stall)
		else $error("weight access did not hold off the next word");

endmodule

bind som_bmu_search_and_update_unit som_chk u_som_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

// ===== sim/tb_som_bmu_search_and_update_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for som_bmu_search_and_update_unit: weight access, BMU search,
// Kohonen update, length and index errors, back-pressure. Depends on som_pkg and the block itself.
module tb_som_bmu_search_and_update_unit;
	import som_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	som_bmu_search_and_update_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Mirror of the block's state and registers
	longint rate_init, radius_init, rate_decay, radius_decay, rows, cols, dims;
	longint rate_now, radius_now, elem_count;
	shortint weights [MAX_NEURONS*MAX_DIMS];
	bit written [MAX_NEURONS*MAX_DIMS];
	shortint in_vec [MAX_DIMS];
	longint exp_tab [EXP_TABLE_DEPTH];

	rsp_t expected_rsp [$];
	int errors = 0;
	bit idle_on = 1'b1;
	bit long_hold = 1'b0;

	function automatic longint neurons();
		longint n;
		n = rows * cols;
		return (n > MAX_NEURONS) ? MAX_NEURONS : n;
	endfunction

	function automatic bit dims_ok();
		return dims >= 1 && dims <= MAX_DIMS;
	endfunction

	// Neighborhood table: Taylor step in Q32.32, then a rounded recurrence
	function automatic void make_exp_table();
		longint unsigned s, term, cur;
		longint sum;
		s = (longint'(12) << 32) / 256;
		term = 64'h1_0000_0000;
		sum = 64'h1_0000_0000;
		cur = 64'h1_0000_0000;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * s) >> 32) / n;
			if (n % 2) sum -= longint'(term); else sum += longint'(term);
		end
		exp_tab[0] = 1 << 24;
		for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
			cur = (cur * longint'(sum) + 64'h8000_0000) >> 32;
			exp_tab[k] = longint'((cur + 128) >> 8);
		end
	endfunction

	function automatic void reset_state();
		rate_init = 9830; radius_init = 12800; rate_decay = 65523; radius_decay = 65529;
		rows = 100; cols = 50; dims = 13;
		rate_now = rate_init; radius_now = radius_init; elem_count = 0;
	endfunction

	// Work out the result (if any) of one accepted word
	function automatic void predict_word(req_t r);
		rsp_t e;
		longint n, total, best, d, diff, win, eff, wr, wc, den, d2, k, h, alpha, nv, rew;
		n = neurons();
		e = '0;
		if (r.action == ACT_WRITE || r.action == ACT_READ) begin
			if (r.neuron_index >= n || !dims_ok() || r.dim_index >= dims) e.status = ST_IDX;
			else if (r.action == ACT_WRITE) begin
				weights[r.neuron_index*MAX_DIMS + r.dim_index] = r.element;
				written[r.neuron_index*MAX_DIMS + r.dim_index] = 1'b1;
			end else e.read_value = weights[r.neuron_index*MAX_DIMS + r.dim_index];
			expected_rsp.push_back(e);
			return;
		end
		if (elem_count < MAX_DIMS) in_vec[elem_count] = r.element;
		total = elem_count + 1;
		if (!r.last) begin
			elem_count = (total > 31) ? 31 : total;
			return;
		end
		elem_count = 0;
		if (!dims_ok() || total != dims) e.status = ST_LEN;
		else if (n == 0 || (r.action == ACT_TRAIN && r.neuron_index >= n)) e.status = ST_IDX;
		else if (r.action == ACT_SEARCH) begin
			best = 0; win = 0;
			for (int i = 0; i < n; i++) begin
				d = 0;
				for (int j = 0; j < dims; j++) begin
					diff = longint'(in_vec[j]) - longint'(weights[i*MAX_DIMS + j]);
					d += diff * diff;
				end
				if (i == 0 || d < best) begin
					best = d; win = i;
				end
			end
			e.winner = win;
			e.best_distance = (best > 64'h1F_FFFF_FFFF) ? 37'h1F_FFFF_FFFF : best;
		end else begin
			rew = (r.reward_scale < 0) ? 0 : longint'(r.reward_scale);
			eff = (rate_now * rew) >> 12;
			if (eff != 0) begin
				wr = r.neuron_index / cols; wc = r.neuron_index % cols;
				den = 24 * radius_now * radius_now;
				for (int i = 0; i < n; i++) begin
					d2 = (i/cols - wr) * (i/cols - wr) + (i%cols - wc) * (i%cols - wc);
					if (den == 0) h = (d2 == 0) ? exp_tab[0] : 0;
					else begin
						k = d2 * 65536 * EXP_TABLE_DEPTH / den;
						h = (k < EXP_TABLE_DEPTH) ? exp_tab[k] : 0;
					end
					if (h < 168) continue;
					alpha = (eff * h) >> 24;
					for (int j = 0; j < dims; j++) begin
						diff = longint'(in_vec[j]) - longint'(weights[i*MAX_DIMS + j]);
						// round half up: floor of (p + half)
						nv = longint'(weights[i*MAX_DIMS + j]) + ((alpha * diff + 32768) >>> 16);
						if (nv > 32767) nv = 32767;
						if (nv < -32768) nv = -32768;
						weights[i*MAX_DIMS + j] = shortint'(nv);
					end
				end
			end
			rate_now = (rate_now * rate_decay) >> 16;
			radius_now = (radius_now * radius_decay) >> 16;
		end
		expected_rsp.push_back(e);
	endfunction

	// Check every accepted result word against the oldest expectation
	always @(posedge clk) begin
		rsp_t e;
		if (rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected result word %h", rsp_data);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp_data.winner !== e.winner) begin
					$error("winner exp %0d got %0d", e.winner, rsp_data.winner); errors++;
				end
				if (rsp_data.best_distance !== e.best_distance) begin
					$error("best_distance exp %0d got %0d", e.best_distance,
						rsp_data.best_distance); errors++;
				end
				if (rsp_data.read_value !== e.read_value) begin
					$error("read_value exp %0d got %0d", e.read_value, rsp_data.read_value);
					errors++;
				end
				if (rsp_data.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp_data.status); errors++;
				end
			end
		end
	end

	// Receiver: short random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_stall = 1'b1;
				repeat (400) @(negedge clk);
				rsp_stall = 1'b0;
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_stall = 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				rsp_stall = 1'b0;
			end
		end
	end

	// Offer one word at a falling edge, hold it until taken, then drop valid
	task automatic send_word(req_t r);
		req_data = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		predict_word(r);
		@(negedge clk);
		req_valid = 1'b0;
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) @(negedge clk);
	endtask

	task automatic send_access(action_t a, int nidx, int didx, shortint value);
		req_t r;
		r = '0;
		r.action = a; r.neuron_index = nidx; r.dim_index = didx; r.element = value;
		r.last = $urandom_range(0, 1); r.reward_scale = $urandom;
		send_word(r);
	endtask

	// Stream a vector of len elements; the final one carries winner and reward
	task automatic send_vector(action_t a, int len, int nidx, shortint reward);
		req_t r;
		for (int i = 0; i < len; i++) begin
			r.action = a; r.element = $urandom; r.last = (i == len - 1);
			r.neuron_index = $urandom; r.dim_index = $urandom; r.reward_scale = $urandom;
			if (r.last) begin
				r.neuron_index = nidx; r.reward_scale = reward;
			end
			send_word(r);
		end
	endtask

	// Hold the sender until every expected word has come, then let the block settle
	task automatic drain();
		wait (expected_rsp.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		drain();
		cfg_index = idx; cfg_data = value; cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_INIT_RATE: begin
				rate_init = value & 16'hFFFF; rate_now = rate_init;
			end
			REG_INIT_RADIUS: begin
				radius_init = value & 16'hFFFF; radius_now = radius_init;
			end
			REG_RATE_DECAY: rate_decay = value & 16'hFFFF;
			REG_RADIUS_DECAY: radius_decay = value & 16'hFFFF;
			REG_GRID_ROWS: rows = value & 8'hFF;
			REG_GRID_COLS: cols = value & 8'hFF;
			REG_VECTOR_DIMS: dims = value & 5'h1F;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_grid(int r, int c, int d);
		write_reg(REG_GRID_ROWS, r);
		write_reg(REG_GRID_COLS, c);
		write_reg(REG_VECTOR_DIMS, d);
	endtask

	// Write every weight of the grid in use so searches never touch unset entries
	task automatic fill_grid();
		for (int i = 0; i < neurons(); i++)
			for (int j = 0; j < dims; j++)
				send_access(ACT_WRITE, i, j, $urandom);
	endtask

	task automatic test_weight_access();
		// defaults: 5000 neurons, 13 dims
		send_access(ACT_WRITE, 4999, 12, 16'sh7FFF);
		send_access(ACT_READ, 4999, 12, 0);
		send_access(ACT_WRITE, 5000, 0, 1);
		send_access(ACT_READ, 0, 13, 0);
		// full capacity, widest vectors
		set_grid(128, 128, 16);
		send_access(ACT_WRITE, 8191, 15, 16'sh8000);
		send_access(ACT_READ, 8191, 15, 0);
		send_access(ACT_READ, 4999, 12, 0);
	endtask

	task automatic test_search();
		set_grid(2, 2, 3);
		fill_grid();
		// identical weights: the lowest index must win the tie
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 3; j++) send_access(ACT_WRITE, i, j, 16'sh1000);
		send_vector(ACT_SEARCH, 3, 0, 0);
		send_vector(ACT_SEARCH, 3, 0, 0);
	endtask

	task automatic test_train();
		write_reg(REG_INIT_RATE, 65535);
		write_reg(REG_RATE_DECAY, 65535);
		write_reg(REG_RADIUS_DECAY, 0);
		write_reg(REG_INIT_RADIUS, 256);
		send_vector(ACT_TRAIN, 3, 3, 16'sh7FFF);
		// radius has decayed to zero: only the winner moves
		send_vector(ACT_TRAIN, 3, 1, 16'sh1000);
		send_vector(ACT_SEARCH, 3, 0, 0);
		// negative reward acts as zero, decay still applies
		write_reg(REG_INIT_RADIUS, 65535);
		send_vector(ACT_TRAIN, 3, 0, 16'sh8000);
		write_reg(REG_INIT_RATE, 0);
		send_vector(ACT_TRAIN, 3, 2, 16'sh4000);
		write_reg(REG_INIT_RATE, 9830);
		write_reg(REG_RATE_DECAY, 0);
		write_reg(REG_RADIUS_DECAY, 65535);
		write_reg(REG_INIT_RADIUS, 1);
		send_vector(ACT_TRAIN, 3, 2, 16'sh2000);
	endtask

	task automatic test_length_errors();
		send_vector(ACT_SEARCH, 2, 0, 0);
		send_vector(ACT_TRAIN, 4, 0, 16'sh1000);
		// more than 31 elements: the count saturates
		send_vector(ACT_SEARCH, 34, 0, 0);
		write_reg(REG_VECTOR_DIMS, 0);
		send_vector(ACT_SEARCH, 1, 0, 0);
		send_access(ACT_READ, 0, 0, 0);
		write_reg(REG_VECTOR_DIMS, 31);
		send_vector(ACT_TRAIN, 31, 0, 16'sh1000);
		write_reg(REG_VECTOR_DIMS, 3);
	endtask

	task automatic test_index_errors();
		send_vector(ACT_TRAIN, 3, 4, 16'sh1000);
		send_vector(ACT_TRAIN, 3, 8191, 16'sh1000);
		send_access(ACT_WRITE, 4, 0, 5);
		send_access(ACT_READ, 0, 3, 0);
		// empty grid
		write_reg(REG_GRID_ROWS, 0);
		send_vector(ACT_SEARCH, 3, 0, 0);
		send_vector(ACT_TRAIN, 3, 0, 16'sh1000);
		write_reg(REG_GRID_ROWS, 2);
	endtask

	task automatic test_backpressure();
		// hold the result side for a long stretch while reads keep coming
		long_hold = 1'b1;
		for (int i = 0; i < 8; i++) send_access(ACT_READ, $urandom_range(0, 3),
			$urandom_range(0, 2), 0);
		drain();
		send_vector(ACT_SEARCH, 3, 0, 0);
	endtask

	task automatic test_random();
		int nidx, didx, kind;
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 2) idle_on = 1'b0;
			set_grid($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 16));
			write_reg(REG_INIT_RATE, $urandom);
			write_reg(REG_INIT_RADIUS, $urandom_range(1, 2048));
			write_reg(REG_RATE_DECAY, $urandom_range(60000, 65535));
			write_reg(REG_RADIUS_DECAY, $urandom_range(60000, 65535));
			fill_grid();
			for (int it = 0; it < 14; it++) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) send_vector(ACT_SEARCH, dims, 0, 0);
				else if (kind < 7) send_vector(ACT_TRAIN, dims,
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, neurons() - 1),
					$urandom);
				else if (kind == 7) send_vector(action_t'($urandom_range(0, 1)),
					$urandom_range(1, 20), $urandom, $urandom);
				else begin
					nidx = $urandom_range(0, neurons() - 1);
					didx = $urandom_range(0, dims - 1);
					if ($urandom_range(0, 2) == 0) begin
						nidx = $urandom; didx = $urandom;
					end
					send_access(action_t'($urandom_range(2, 3)), nidx, didx, $urandom);
				end
			end
		end
	endtask

	initial begin
		make_exp_table();
		reset_state();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_weight_access();
		test_search();
		test_train();
		test_length_errors();
		test_index_errors();
		test_backpressure();
		test_random();
		wait (expected_rsp.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/som_pkg.sv
sv/som_wmem.sv
sv/som_div.sv
sv/som_bmu_search_and_update_unit.sv
sv/som_chk.sv
sim/tb_som_bmu_search_and_update_unit.sv
